### sv/lia_pkg.sv
// ----------------------------------------------------------------------------
// lia_pkg: shared constants and functions for the interpolated atan2 block
// Holds the Q2.30 angle constants and the function that builds the
// arctangent table entries at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package lia_pkg;

	// Internal angle format is unsigned/signed Q2.30.
	localparam int WORK_FRAC   = 30;
	// Ratio of the smaller to the larger magnitude, Q0.16 plus the integer bit.
	localparam int RATIO_FRAC  = 16;
	localparam int QBITS       = RATIO_FRAC + 1;
	// Width of a table entry (pi/4 in Q2.30 stays below 2^30).
	localparam int ROM_W       = 30;
	// Width of the base angle and of the folded angle.
	localparam int BASE_W      = 31;
	localparam int ANG_W       = 33;
	localparam int CORDIC_STEPS = 31;

	localparam logic signed [ANG_W-1:0] PI_Q30      = 33'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

	localparam longint STEP_ANGLES [CORDIC_STEPS] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
		128, 64, 32, 16, 8, 4, 2, 1
	};

	// Arithmetic shift that truncates toward zero.
	function automatic longint shr_signed(input longint v, input int s);
		longint r;
		if (v >= 0) begin
			r = v >>> s;
		end else begin
			r = -((-v) >>> s);
		end
		return r;
	endfunction

	// atan(k/ts) in Q2.30 by an integer CORDIC in vectoring mode.
	function automatic logic [ROM_W-1:0] atan_entry(input int k, input int ts);
		longint x;
		longint y;
		longint acc;
		longint dx;
		longint dy;
		logic [ROM_W-1:0] res;
		res = '0;
		if (k >= ts) begin
			res = ROM_W'(STEP_ANGLES[0]);
		end else if (k > 0) begin
			x   = longint'(ts) <<< 32;
			y   = longint'(k) <<< 32;
			acc = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = shr_signed(y, i);
				dy = shr_signed(x, i);
				if (y >= 0) begin
					x   = x + dx;
					y   = y - dy;
					acc = acc + STEP_ANGLES[i];
				end else begin
					x   = x - dx;
					y   = y + dy;
					acc = acc - STEP_ANGLES[i];
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			res = ROM_W'(acc);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### sv/lut_interpolated_atan2.sv
// ----------------------------------------------------------------------------
// lut_interpolated_atan2: pipelined four-quadrant arctangent
// Gives the angle of a signed vector in Q2.ANGLE_FRAC_BITS radians from a
// restoring divider, an interpolated arctangent table and octant folding.
// ----------------------------------------------------------------------------
//
// Channel | Signals                          | Direction
// --------+----------------------------------+----------
// input   | in_valid, in_stall, x_in, y_in   | in (in_stall out)
// output  | out_valid, out_stall, angle      | out (out_stall in)
//
// A transaction enters every cycle while in_stall is low. Every transaction takes
// the same path, whatever the input value, through 24 register stages (one entry
// stage, 17 divider stages, six arithmetic stages). Most of them belong to the
// restoring divider, which retires one quotient bit per stage. Reset clears only
// the valid bits of the stages.
// A stall on the output holds the last stage; bubbles further up still close,
// so the input keeps taking transactions until every stage holds one.
`default_nettype none

module lut_interpolated_atan2 #(
	parameter int INPUT_BITS      = 16,
	parameter int TABLE_STEPS     = 255,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [INPUT_BITS-1:0]      x_in,
	input  wire logic signed [INPUT_BITS-1:0]      y_in,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [ANGLE_FRAC_BITS+2:0]      angle
);

	localparam int IB     = INPUT_BITS;
	localparam int QB     = lia_pkg::QBITS;
	localparam int TW     = $clog2(TABLE_STEPS + 1);
	localparam int SCW    = QB + TW;
	localparam int OW     = ANGLE_FRAC_BITS + 3;
	localparam int SH     = lia_pkg::WORK_FRAC - ANGLE_FRAC_BITS;
	localparam int NST    = QB + 7;
	localparam int S3     = QB + 1;
	localparam int S8     = QB + 6;
	localparam int SMALL_LIM = 65536 / TABLE_STEPS;
	localparam int RF     = lia_pkg::RATIO_FRAC;
	localparam int BW     = lia_pkg::BASE_W;
	localparam int AW     = lia_pkg::ANG_W;
	localparam int RW     = lia_pkg::ROM_W;

	localparam logic [TW-1:0] TS_C    = TW'(TABLE_STEPS);
	localparam logic [QB-1:0] SMALL_C = QB'(SMALL_LIM);

	// Side information that follows each transaction down the pipe.
	typedef struct packed {
		logic xneg;
		logic yneg;
		logic xgt;
		logic zero;
	} side_t;

	// Arctangent table, one entry per step from 0 to pi/4, fixed at elaboration.
	logic [RW-1:0] rom_tbl [TABLE_STEPS+1];
	for (genvar g = 0; g <= TABLE_STEPS; g++) begin : g_rom
		assign rom_tbl[g] = lia_pkg::atan_entry(g, TABLE_STEPS);
	end

	// Stage valid bits and advance enables. A stage moves when it is empty or
	// its successor moves, so bubbles close up behind a stalled output.
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || !out_stall;
		for (int i = NST - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: magnitudes, ordering and flags.
	// ------------------------------------------------------------------
	logic [IB-1:0] xa;
	logic [IB-1:0] ya;
	logic          xgt;
	logic [IB-1:0] lo_s1;
	logic [IB-1:0] hi_s1;
	side_t         sd_s1;

	// The most negative input maps to 2^(IB-1), which still fits unsigned.
	assign xa  = x_in[IB-1] ? (~x_in) + 1'b1 : x_in;
	assign ya  = y_in[IB-1] ? (~y_in) + 1'b1 : y_in;
	assign xgt = xa > ya;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			lo_s1        <= xgt ? ya : xa;
			hi_s1        <= xgt ? xa : ya;
			sd_s1.xneg   <= x_in[IB-1];
			sd_s1.yneg   <= y_in[IB-1];
			sd_s1.xgt    <= xgt;
			sd_s1.zero   <= (xa == '0) && (ya == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: restoring divider, one quotient bit per stage, MSB first.
	// The remainder stays below the divisor whenever the divisor is nonzero.
	// ------------------------------------------------------------------
	logic [IB-1:0] drem_s2 [QB];
	logic [IB-1:0] dhi_s2  [QB];
	logic [QB-1:0] dq_s2   [QB];
	side_t         dsd_s2  [QB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [IB:0]   trial;
		logic [IB:0]   divisor;
		logic          ge;
		logic [IB-1:0] hi_in;
		logic [QB-1:0] q_in;
		side_t         sd_in;

		if (j == 0) begin : g_first
			assign trial = {1'b0, lo_s1};
			assign hi_in = hi_s1;
			assign q_in  = '0;
			assign sd_in = sd_s1;
		end else begin : g_next
			assign trial = {drem_s2[j-1], 1'b0};
			assign hi_in = dhi_s2[j-1];
			assign q_in  = dq_s2[j-1];
			assign sd_in = dsd_s2[j-1];
		end

		assign divisor = {1'b0, hi_in};
		assign ge      = trial >= divisor;

		always_ff @(posedge clk) begin
			if (en[j+1]) begin
				drem_s2[j] <= ge ? IB'(trial - divisor) : IB'(trial);
				dhi_s2[j]  <= hi_in;
				dq_s2[j]   <= {q_in[QB-2:0], ge};
				dsd_s2[j]  <= sd_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: scale the ratio by the table step count.
	// ------------------------------------------------------------------
	logic [QB-1:0]  ratio_s3;
	logic [SCW-1:0] scaled_s3;
	logic           small_s3;
	side_t          sd_s3;

	always_ff @(posedge clk) begin
		if (en[S3]) begin
			ratio_s3  <= dq_s2[QB-1];
			scaled_s3 <= SCW'(dq_s2[QB-1]) * SCW'(TABLE_STEPS);
			small_s3  <= dq_s2[QB-1] < SMALL_C;
			sd_s3     <= dsd_s2[QB-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: read the two neighboring table entries.
	// ------------------------------------------------------------------
	logic [TW-1:0] pos;
	logic [TW-1:0] pos_nx;
	logic [RW-1:0] e0_s4;
	logic [RW-1:0] e1_s4;
	logic [RF-1:0] frac_s4;
	logic [QB-1:0] ratio_s4;
	logic          small_s4;
	side_t         sd_s4;

	// Only a ratio of exactly one lands on the last entry, with no fraction.
	assign pos    = scaled_s3[RF +: TW];
	assign pos_nx = (pos == TS_C) ? pos : pos + 1'b1;

	always_ff @(posedge clk) begin
		if (en[S3+1]) begin
			e0_s4    <= rom_tbl[pos];
			e1_s4    <= rom_tbl[pos_nx];
			frac_s4  <= scaled_s3[RF-1:0];
			ratio_s4 <= ratio_s3;
			small_s4 <= small_s3;
			sd_s4    <= sd_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: slope times fraction, truncated toward zero.
	// ------------------------------------------------------------------
	logic signed [RW:0] diff;
	logic [RW-1:0]      dmag;
	logic [RW-1:0]      pmag_s5;
	logic               pneg_s5;
	logic [RW-1:0]      e0_s5;
	logic [QB-1:0]      ratio_s5;
	logic               small_s5;
	side_t              sd_s5;
	logic [RW+RF-1:0]   prod;

	assign diff = $signed({1'b0, e1_s4}) - $signed({1'b0, e0_s4});
	assign dmag = diff[RW] ? RW'(-diff) : RW'(diff);
	assign prod = (RW+RF)'(dmag) * (RW+RF)'(frac_s4);

	always_ff @(posedge clk) begin
		if (en[S3+2]) begin
			pmag_s5  <= prod[RF +: RW];
			pneg_s5  <= diff[RW];
			e0_s5    <= e0_s4;
			ratio_s5 <= ratio_s4;
			small_s5 <= small_s4;
			sd_s5    <= sd_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: base angle in the first octant.
	// ------------------------------------------------------------------
	logic [BW-1:0] base_s6;
	side_t         sd_s6;
	logic [BW-1:0] interp;

	assign interp = pneg_s5 ? BW'(e0_s5) - BW'(pmag_s5) : BW'(e0_s5) + BW'(pmag_s5);

	always_ff @(posedge clk) begin
		if (en[S3+3]) begin
			base_s6 <= small_s5 ? (BW'(ratio_s5) << (lia_pkg::WORK_FRAC - RF)) : interp;
			sd_s6   <= sd_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: fold the base angle into its octant.
	// ------------------------------------------------------------------
	logic signed [AW-1:0] base_sx;
	logic signed [AW-1:0] fold;
	logic signed [AW-1:0] ang_s7;
	logic                 zero_s7;

	assign base_sx = $signed({2'b00, base_s6});

	always_comb begin
		if (sd_s6.xgt) begin
			if (!sd_s6.xneg) begin
				fold = sd_s6.yneg ? -base_sx : base_sx;
			end else begin
				fold = sd_s6.yneg ? base_sx - lia_pkg::PI_Q30 : lia_pkg::PI_Q30 - base_sx;
			end
		end else begin
			if (!sd_s6.yneg) begin
				fold = sd_s6.xneg ? lia_pkg::HALF_PI_Q30 + base_sx
				                  : lia_pkg::HALF_PI_Q30 - base_sx;
			end else begin
				fold = sd_s6.xneg ? -lia_pkg::HALF_PI_Q30 - base_sx
				                  : base_sx - lia_pkg::HALF_PI_Q30;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[S3+4]) begin
			ang_s7  <= fold;
			zero_s7 <= sd_s6.zero;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: round half away from zero to the output format.
	// ------------------------------------------------------------------
	logic [AW-1:0] amag;
	logic [AW-1:0] rsum;
	logic [OW-1:0] rmag;
	logic [OW-1:0] angle_s8;

	assign amag = ang_s7[AW-1] ? AW'(-ang_s7) : AW'(ang_s7);
	assign rsum = amag + (AW'(1) << (SH - 1));
	assign rmag = OW'(rsum >> SH);

	always_ff @(posedge clk) begin
		if (en[S8]) begin
			if (zero_s7) begin
				angle_s8 <= '0;
			end else begin
				angle_s8 <= ang_s7[AW-1] ? OW'(-rmag) : rmag;
			end
		end
	end

	assign angle = $signed(angle_s8);

endmodule

`default_nettype wire

### sv/lia_checker.sv
// ----------------------------------------------------------------------------
// lia_checker: port-level checks for the interpolated atan2 block
// Watches the handshakes and the result range of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lia_checker #(
	parameter int ANGLE_FRAC_BITS = 13
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic signed [ANGLE_FRAC_BITS+2:0] angle
);

	localparam int OW = ANGLE_FRAC_BITS + 3;
	// pi rounded to nearest in the output format bounds every legal result.
	localparam logic signed [OW-1:0] PI_OUT =
		OW'((lia_pkg::PI_Q30 + (longint'(1) << (lia_pkg::WORK_FRAC - ANGLE_FRAC_BITS - 1)))
		    >>> (lia_pkg::WORK_FRAC - ANGLE_FRAC_BITS));

	// A held result stays on the port until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(angle))
		else $error("result changed while stalled");

	// The input only backs up when the output is full and stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	// Every result lies within plus and minus pi.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle <= PI_OUT) && (angle >= -PI_OUT))
		else $error("angle out of range");

	// Nothing comes out in the cycle right after reset.
	a_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result right after reset");

	// The input is not stalled while the output stage is empty.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("stall with empty output");

endmodule

bind lut_interpolated_atan2 lia_checker #(
	.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_lia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.angle     (angle)
);

`default_nettype wire
